>>> rtl/multichannel_windowed_pid_unit_assert.svh
// ----------------------------------------------------------------------------
// multichannel_windowed_pid_unit_assert.svh - assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_WINDOWED_PID_UNIT_ASSERT_SVH
`define MULTICHANNEL_WINDOWED_PID_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// checked on every clock edge outside reset
`define MWPU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked on every clock edge, reset included
`define MWPU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MWPU_ASSERT(lbl, prop, msg)
`define MWPU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/mwpid_pkg.sv
// ----------------------------------------------------------------------------
// mwpid_pkg - shared types and constants
// beat formats, register indexes, reset values and divide-by-5 constants
// ----------------------------------------------------------------------------
package mwpid_pkg;

    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;

    localparam logic signed [7:0] TARGET_LIMIT = 8'sd100;
    localparam logic signed [7:0] TARGET_RST   = 8'sd0;
    localparam logic [23:0] GAIN_P_RST = 24'd65536;
    localparam logic [23:0] GAIN_I_RST = 24'd13107;
    localparam logic [23:0] GAIN_D_RST = 24'd655;

    // derivative period, gain_d is split as 20*q + r
    localparam int DERIV_PERIOD = 20;
    localparam int GAIN_DQ_W    = 20;
    localparam int GAIN_DR_W    = 5;
    localparam logic [GAIN_DQ_W-1:0] GAIN_DQ_RST =
        GAIN_DQ_W'(int'(GAIN_D_RST) / DERIV_PERIOD);

    // floor(n/5) = (n * DIV5_MULT) >> DIV5_SHIFT, exact for n < 2**22
    localparam int DIV5_SHIFT  = 25;
    localparam int DIV5_MULT_W = 23;
    localparam logic [DIV5_MULT_W-1:0] DIV5_MULT =
        DIV5_MULT_W'(((1 << DIV5_SHIFT) + 4) / 5);

    typedef struct packed {
        logic [1:0]         channel;
        logic signed [15:0] measured_count;
    } sample_t;

    typedef struct packed {
        logic [1:0]         out_channel;
        logic signed [31:0] drive;
        logic signed [15:0] speed_error;
        logic               saturated;
    } result_t;

    typedef struct packed {
        logic signed [7:0]      target_velocity;
        logic [23:0]            gain_p;
        logic [23:0]            gain_i;
        logic [GAIN_DQ_W-1:0]   gain_dq;
        logic [GAIN_DR_W-1:0]   gain_dr;
    } cfg_t;

    // classified item between front and back
    typedef struct packed {
        logic [1:0]         channel;
        logic               chan_ok;
        logic signed [15:0] error;
        logic               error_sat;
    } work_t;

endpackage

>>> rtl/mwpid_cfg.sv
// ----------------------------------------------------------------------------
// mwpid_cfg - configuration registers
// target clamp on write, gains, derivative gain split by the period
// ----------------------------------------------------------------------------
module mwpid_cfg
    import mwpid_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    localparam int PROD_W = (CFG_DATA_W - 2) + DIV5_MULT_W;

    logic signed [7:0]    target_reg, target_next;
    logic [23:0]          gain_p_reg, gain_p_next;
    logic [23:0]          gain_i_reg, gain_i_next;
    logic [23:0]          gain_d_reg, gain_d_next;
    logic [GAIN_DQ_W-1:0] gain_dq_reg, gain_dq_next;
    logic signed [7:0]    wr_target;
    logic [PROD_W-1:0]    dq_prod;
    logic [23:0]          dr_full;

    always_comb
    begin
        wr_target = $signed(cfg_data[7:0]);
        if (wr_target > TARGET_LIMIT)
        begin
            wr_target = TARGET_LIMIT;
        end
        else if (wr_target < -TARGET_LIMIT)
        begin
            wr_target = -TARGET_LIMIT;
        end
    end

    always_comb
    begin
        target_next = target_reg;
        gain_p_next = gain_p_reg;
        gain_i_next = gain_i_reg;
        gain_d_next = gain_d_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TARGET: target_next = wr_target;
                REG_GAIN_P: gain_p_next = cfg_data[23:0];
                REG_GAIN_I: gain_i_next = cfg_data[23:0];
                REG_GAIN_D: gain_d_next = cfg_data[23:0];
                default:    target_next = target_reg;
            endcase
        end
    end

    // gain_d / 20 as (gain_d >> 2) / 5, registered in the cycle after gain_d
    assign dq_prod      = PROD_W'(gain_d_reg[23:2]) * PROD_W'(DIV5_MULT);
    assign gain_dq_next = dq_prod[DIV5_SHIFT +: GAIN_DQ_W];
    assign dr_full      = gain_d_reg - 24'(24'(gain_dq_reg) * 24'(DERIV_PERIOD));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= TARGET_RST;
            gain_p_reg  <= GAIN_P_RST;
            gain_i_reg  <= GAIN_I_RST;
            gain_d_reg  <= GAIN_D_RST;
            gain_dq_reg <= GAIN_DQ_RST;
        end
        else
        begin
            target_reg  <= target_next;
            gain_p_reg  <= gain_p_next;
            gain_i_reg  <= gain_i_next;
            gain_d_reg  <= gain_d_next;
            gain_dq_reg <= gain_dq_next;
        end
    end

    assign cfg.target_velocity = target_reg;
    assign cfg.gain_p          = gain_p_reg;
    assign cfg.gain_i          = gain_i_reg;
    assign cfg.gain_dq         = gain_dq_reg;
    assign cfg.gain_dr         = dr_full[GAIN_DR_W-1:0];

endmodule

>>> rtl/mwpid_front.sv
// ----------------------------------------------------------------------------
// mwpid_front - sample intake
// classifies the channel, forms the saturated error, two-entry queue
// ----------------------------------------------------------------------------
module mwpid_front
    import mwpid_pkg::*;
#(
    parameter int CHANNELS = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  sample_t           sample,
    input  logic signed [7:0] target_velocity,
    input  logic              clear_busy,
    output logic              q_valid,
    input  logic              q_ready,
    output work_t             q_item
);

    localparam int QDEPTH = 2;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    work_t              fifo_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               push, pop;
    logic signed [16:0] diff;
    work_t              item_in;

    // target - count with 17-bit headroom, then clip to 16 bits
    assign diff = {{9{target_velocity[7]}}, target_velocity}
                - {sample.measured_count[15], sample.measured_count};

    always_comb
    begin
        item_in.channel   = sample.channel;
        item_in.chan_ok   = int'(sample.channel) < CHANNELS;
        item_in.error     = diff[15:0];
        item_in.error_sat = 1'b0;
        if (diff[16] != diff[15])
        begin
            item_in.error_sat = 1'b1;
            item_in.error     = diff[16] ? 16'sh8000 : 16'sh7fff;
        end
        if (!item_in.chan_ok)
        begin
            item_in.error     = '0;
            item_in.error_sat = 1'b0;
        end
    end

    assign sample_ready = !clear_busy && (cnt_reg != CNT_W'(QDEPTH));
    assign push         = sample_valid && sample_ready;
    assign q_valid      = cnt_reg != '0;
    assign pop          = q_valid && q_ready;
    assign q_item       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

>>> rtl/mwpid_back.sv
// ----------------------------------------------------------------------------
// mwpid_back - ring update and drive pipeline
// per-channel ring memory, window sums, multiply pipeline, output register
// ----------------------------------------------------------------------------
`include "multichannel_windowed_pid_unit_assert.svh"

module mwpid_back
    import mwpid_pkg::*;
#(
    parameter int CHANNELS = 4,
    parameter int WINDOW   = 20
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    q_valid,
    output logic    q_ready,
    input  work_t   q_item,
    output logic    clear_busy,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int POS_W     = $clog2(WINDOW);
    localparam int MEM_AW    = CH_W + POS_W;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int SUM_W     = 16 + $clog2(WINDOW);
    localparam int P_W       = 41;
    localparam int I_W       = 25 + SUM_W;
    localparam int PI_W      = I_W + 1;
    localparam int DQ_W      = GAIN_DQ_W + 16;
    localparam int DR_W      = GAIN_DR_W + 16;
    localparam int DRP_W     = (DR_W - 2) + DIV5_MULT_W;
    localparam int DM_W      = DQ_W + 1;
    localparam int ACC_W     = (I_W + 2 > 49) ? I_W + 2 : 49;
    localparam int SH_W      = ACC_W - 16;

    // ring memory
    logic signed [15:0]     ring_mem [MEM_DEPTH];
    logic                   mem_we;
    logic [MEM_AW-1:0]      mem_waddr;
    logic signed [15:0]     mem_wdata;

    // clearing pass
    logic                   clr_busy_reg, clr_busy_next;
    logic [MEM_AW-1:0]      clr_addr_reg, clr_addr_next;

    // per-channel state
    logic [POS_W-1:0]       wp_reg [CHANNELS];
    logic signed [15:0]     last_err_reg [CHANNELS];
    logic signed [SUM_W-1:0] sum_reg [CHANNELS];

    logic                   adv;
    logic                   iss_fire, iss_ok;
    logic [CH_W-1:0]        iss_ch;
    logic [POS_W-1:0]       pos_cur, pos_new;
    logic [MEM_AW-1:0]      rd_addr;
    logic signed [SUM_W-1:0] sum_fwd;

    // stage 1: ring read data back
    logic                   s1_valid_reg;
    work_t                  s1_item_reg;
    logic signed [15:0]     s1_prev_reg;
    logic signed [SUM_W-1:0] s1_sum_reg;
    logic [MEM_AW-1:0]      s1_addr_reg;
    logic signed [15:0]     rd_data_reg;
    logic                   s1_ok;
    logic [CH_W-1:0]        s1_ch;
    logic signed [SUM_W-1:0] s1_sum_new;
    logic signed [16:0]     s1_diff, s1_diff_neg;
    logic [15:0]            s1_absd;

    // stage 2: products
    logic                   s2_valid_reg;
    work_t                  s2_item_reg;
    logic signed [SUM_W-1:0] s2_sum_reg;
    logic [15:0]            s2_absd_reg;
    logic                   s2_dneg_reg;
    logic signed [P_W-1:0]  s2_p;
    logic signed [I_W-1:0]  s2_i;
    logic [DQ_W-1:0]        s2_dq;
    logic [DR_W-1:0]        s2_dr;

    // stage 3: p + i, remainder divide
    logic                   s3_valid_reg;
    work_t                  s3_item_reg;
    logic signed [P_W-1:0]  s3_p_reg;
    logic signed [I_W-1:0]  s3_i_reg;
    logic [DQ_W-1:0]        s3_dq_reg;
    logic [DR_W-1:0]        s3_dr_reg;
    logic                   s3_dneg_reg;
    logic signed [PI_W-1:0] s3_pi;
    logic [DRP_W-1:0]       s3_drp;

    // stage 4: derivative magnitude
    logic                   s4_valid_reg;
    work_t                  s4_item_reg;
    logic signed [PI_W-1:0] s4_pi_reg;
    logic [DQ_W-1:0]        s4_dq_reg;
    logic [DRP_W-1:0]       s4_drp_reg;
    logic                   s4_dneg_reg;
    logic [DM_W-1:0]        s4_dmag;

    // stage 5: accumulate
    logic                   s5_valid_reg;
    work_t                  s5_item_reg;
    logic signed [PI_W-1:0] s5_pi_reg;
    logic [DM_W-1:0]        s5_dmag_reg;
    logic                   s5_dneg_reg;
    logic signed [ACC_W-1:0] s5_acc;

    // stage 6: shift and saturate
    logic                   s6_valid_reg;
    work_t                  s6_item_reg;
    logic signed [ACC_W-1:0] s6_acc_reg;
    logic signed [SH_W-1:0] s6_sh;
    logic                   s6_pos_ovf, s6_neg_ovf;
    result_t                s6_result;

    logic                   out_valid_reg;
    result_t                out_reg;

    assign adv        = !out_valid_reg || result_ready;
    assign clear_busy = clr_busy_reg;

    // clearing sweep, one entry a cycle
    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + MEM_AW'(1);
            if (clr_addr_reg == {MEM_AW{1'b1}})
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // issue: advance write position, read the entry that drops out
    assign q_ready  = adv && !clr_busy_reg;
    assign iss_fire = q_valid && q_ready;
    assign iss_ok   = iss_fire && q_item.chan_ok;
    assign iss_ch   = CH_W'(q_item.channel);
    assign pos_cur  = wp_reg[iss_ch];
    assign pos_new  = (int'(pos_cur) == WINDOW - 1) ? '0 : pos_cur + POS_W'(1);
    assign rd_addr  = {iss_ch, pos_new};

    // stage 1 may hold a newer sum for the same channel
    assign s1_ok   = s1_valid_reg && s1_item_reg.chan_ok;
    assign s1_ch   = s1_addr_reg[MEM_AW-1:POS_W];
    assign sum_fwd = (s1_ok && (s1_ch == iss_ch)) ? s1_sum_new : sum_reg[iss_ch];

    assign s1_sum_new  = s1_sum_reg - SUM_W'(rd_data_reg) + SUM_W'(s1_item_reg.error);
    assign s1_diff     = 17'(s1_item_reg.error) - 17'(s1_prev_reg);
    assign s1_diff_neg = -s1_diff;
    assign s1_absd     = s1_diff[16] ? s1_diff_neg[15:0] : s1_diff[15:0];

    assign mem_we    = clr_busy_reg || (adv && s1_ok);
    assign mem_waddr = clr_busy_reg ? clr_addr_reg : s1_addr_reg;
    assign mem_wdata = clr_busy_reg ? 16'sd0 : s1_item_reg.error;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (adv && iss_ok)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                wp_reg[i]       <= '0;
                last_err_reg[i] <= '0;
                sum_reg[i]      <= '0;
            end
        end
        else
        begin
            if (iss_ok)
            begin
                wp_reg[iss_ch]       <= pos_new;
                last_err_reg[iss_ch] <= q_item.error;
            end
            if (adv && s1_ok)
            begin
                sum_reg[s1_ch] <= s1_sum_new;
            end
        end
    end

    // products
    assign s2_p  = P_W'($signed({1'b0, cfg.gain_p})) * P_W'(s2_item_reg.error);
    assign s2_i  = I_W'($signed({1'b0, cfg.gain_i})) * I_W'(s2_sum_reg);
    assign s2_dq = DQ_W'(cfg.gain_dq) * DQ_W'(s2_absd_reg);
    assign s2_dr = DR_W'(cfg.gain_dr) * DR_W'(s2_absd_reg);

    // floor(r*|d|/20) as ((r*|d|) >> 2) / 5
    assign s3_pi  = PI_W'(s3_p_reg) + PI_W'(s3_i_reg);
    assign s3_drp = DRP_W'(s3_dr_reg[DR_W-1:2]) * DRP_W'(DIV5_MULT);

    assign s4_dmag = DM_W'(s4_dq_reg) + DM_W'(s4_drp_reg[DRP_W-1:DIV5_SHIFT]);

    // derivative term truncates toward zero, so the sign goes on last
    assign s5_acc = s5_dneg_reg ? ACC_W'(s5_pi_reg) - $signed(ACC_W'(s5_dmag_reg))
                                : ACC_W'(s5_pi_reg) + $signed(ACC_W'(s5_dmag_reg));

    // arithmetic shift is the floor divide by 65536
    assign s6_sh      = s6_acc_reg[ACC_W-1:16];
    assign s6_pos_ovf = !s6_sh[SH_W-1] && (|s6_sh[SH_W-2:31]);
    assign s6_neg_ovf = s6_sh[SH_W-1] && !(&s6_sh[SH_W-2:31]);

    always_comb
    begin
        s6_result.out_channel = s6_item_reg.channel;
        s6_result.speed_error = s6_item_reg.error;
        s6_result.saturated   = s6_item_reg.error_sat || s6_pos_ovf || s6_neg_ovf;
        if (s6_pos_ovf)
        begin
            s6_result.drive = 32'sh7fffffff;
        end
        else if (s6_neg_ovf)
        begin
            s6_result.drive = 32'sh80000000;
        end
        else
        begin
            s6_result.drive = s6_sh[31:0];
        end
        if (!s6_item_reg.chan_ok)
        begin
            s6_result.drive       = '0;
            s6_result.speed_error = '0;
            s6_result.saturated   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= iss_fire;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            out_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg <= q_item;
            s1_prev_reg <= last_err_reg[iss_ch];
            s1_sum_reg  <= sum_fwd;
            s1_addr_reg <= rd_addr;

            s2_item_reg <= s1_item_reg;
            s2_sum_reg  <= s1_sum_new;
            s2_absd_reg <= s1_absd;
            s2_dneg_reg <= s1_diff[16];

            s3_item_reg <= s2_item_reg;
            s3_p_reg    <= s2_p;
            s3_i_reg    <= s2_i;
            s3_dq_reg   <= s2_dq;
            s3_dr_reg   <= s2_dr;
            s3_dneg_reg <= s2_dneg_reg;

            s4_item_reg <= s3_item_reg;
            s4_pi_reg   <= s3_pi;
            s4_dq_reg   <= s3_dq_reg;
            s4_drp_reg  <= s3_drp;
            s4_dneg_reg <= s3_dneg_reg;

            s5_item_reg <= s4_item_reg;
            s5_pi_reg   <= s4_pi_reg;
            s5_dmag_reg <= s4_dmag;
            s5_dneg_reg <= s4_dneg_reg;

            s6_item_reg <= s5_item_reg;
            s6_acc_reg  <= s5_acc;

            out_reg     <= s6_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `MWPU_ASSERT(a_queue_empty_while_clearing, clr_busy_reg |-> !q_valid, "item queued during ring clear")
    `MWPU_ASSERT(a_ring_port_no_overlap, (mem_we && adv && iss_ok) |-> (mem_waddr != rd_addr), "ring write and read hit one entry")
    `MWPU_ASSERT(a_position_in_window, iss_ok |-> (int'(pos_new) < WINDOW), "write position outside window")
    `MWPU_ASSERT_ALWAYS(a_pipe_empty_while_clearing, clr_busy_reg |-> !(s1_valid_reg || out_valid_reg), "pipeline busy during ring clear")

endmodule

>>> rtl/multichannel_windowed_pid_unit.sv
// ----------------------------------------------------------------------------
// multichannel_windowed_pid_unit - four-channel windowed-integral velocity pid
// Each sample beat carries one encoder count for one wheel channel. The error
// target - count is clipped to 16 bits and stored in that channel's ring of the
// last WINDOW errors, whose running sum feeds the integral term. The drive is
// (gain_p*e + gain_i*sum + trunc(gain_d*(e - e_prev)/20)) >> 16, clipped to
// signed 32 bits, with a flag when the error or the drive clipped. A channel
// number at or above CHANNELS returns a zero result and leaves all state alone.
// Throughput is one sample per cycle unless the output stalls: the ring memory
// takes one read (the entry leaving the window) and one write (the new error)
// each cycle, and the window sum of the channel just before is forwarded. A
// result passes the queue, the stage registers and the output register. After
// reset the ring's (2**ceil(log2 CHANNELS)) * (2**ceil(log2 WINDOW)) entries
// (128 by default) are swept to zero, one per cycle; samples are held off
// during it, register writes are taken as usual. Registers: 0 target (clamped
// to +-100), 1 gain_p, 2 gain_i, 3 gain_d, gains Q8.16; other indexes are
// ignored. Write them only while no sample is in flight; gain_dq lags gain_d.
// ----------------------------------------------------------------------------
module multichannel_windowed_pid_unit
    import mwpid_pkg::*;
#(
    parameter int CHANNELS = 4,
    parameter int WINDOW   = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // register write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // sample beats
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  sample_t               sample,
    // result beats
    output logic                  result_valid,
    input  logic                  result_ready,
    output result_t               result
);

    cfg_t  cfg;
    logic  clear_busy;
    logic  q_valid;
    logic  q_ready;
    work_t q_item;

    // register file, target clamp and gain_d split
    mwpid_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // front: error and channel check, short queue toward the back
    mwpid_front #(
        .CHANNELS (CHANNELS)
    ) u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_valid    (sample_valid),
        .sample_ready    (sample_ready),
        .sample          (sample),
        .target_velocity (cfg.target_velocity),
        .clear_busy      (clear_busy),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item)
    );

    // back: ring update, pid arithmetic, output register
    mwpid_back #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item),
        .clear_busy   (clear_busy),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
